>>> rtl/bes_pkg.sv
// Shared definitions for the bigram encoding scorer.
// Table geometry, total width, opcode codes and the cost table entry type.
// No dependencies.
package bes_pkg;

   // Table geometry
   localparam int SYMBOL_BITS    = 8;
   localparam int SYMBOL_ENTRIES = 1 << SYMBOL_BITS;
   localparam int PAIR_ENTRIES   = 65536;
   localparam int PAIR_BITS      = $clog2(PAIR_ENTRIES);

   // Field and accumulator widths
   localparam int COST_WIDTH  = 16;
   localparam int TOTAL_WIDTH = 40;
   localparam int INDEX_WIDTH = 16;
   localparam int BYTE_WIDTH  = 8;

   // Input opcodes
   typedef enum logic [1:0] {
      OP_SCORE       = 2'd0,
      OP_LOAD_SYMBOL = 2'd1,
      OP_LOAD_PAIR   = 2'd2
   } opcode_type;

   // Model select codes
   localparam logic MODEL_UTF8    = 1'b0;
   localparam logic MODEL_WIN1251 = 1'b1;

   // Verdict codes
   localparam logic GUESS_UTF8    = 1'b0;
   localparam logic GUESS_WIN1251 = 1'b1;

   // One cost table entry: presence bit over the Q6.10 cost
   typedef struct packed {
      logic                  present;
      logic [COST_WIDTH-1:0] cost;
   } cost_entry_type;

endpackage

>>> rtl/bigram_encoding_scorer_top.sv
// A text's last byte passes the scoring stage registers, then the result register.
// Throughput: one beat per cycle, loads and text bytes alike; the input stalls only
// while a text's last byte waits behind a result beat that is held by rsp_stall.
// Reset (synchronous, active high) clears the pipeline valids, totals and previous
// byte and sets the text-start flag; the cost tables are not cleared and must be loaded.
// Depends on bes_pkg.
module bigram_encoding_scorer_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic                             req_model_select,
   input  logic [bes_pkg::INDEX_WIDTH-1:0]  req_table_index,
   input  logic [bes_pkg::COST_WIDTH-1:0]   req_cost_value,
   input  logic                             req_cost_present,
   input  logic [bes_pkg::BYTE_WIDTH-1:0]   req_data_byte,
   input  logic                             req_end_of_text,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_encoding_guess,
   output logic [bes_pkg::TOTAL_WIDTH-1:0]  rsp_score_utf8,
   output logic [bes_pkg::TOTAL_WIDTH-1:0]  rsp_score_win1251
);

   localparam int SB = bes_pkg::SYMBOL_BITS;
   localparam int PB = bes_pkg::PAIR_BITS;
   localparam int TW = bes_pkg::TOTAL_WIDTH;
   localparam int CW = bes_pkg::COST_WIDTH;

   // Cost tables
   bes_pkg::cost_entry_type utf8_sym_mem  [bes_pkg::SYMBOL_ENTRIES];
   bes_pkg::cost_entry_type win_sym_mem   [bes_pkg::SYMBOL_ENTRIES];
   bes_pkg::cost_entry_type utf8_pair_mem [bes_pkg::PAIR_ENTRIES];
   bes_pkg::cost_entry_type win_pair_mem  [bes_pkg::PAIR_ENTRIES];

   // Front end decode
   logic                    accept;
   logic                    is_score;
   logic                    is_load_sym;
   logic                    is_load_pair;
   logic [SB-1:0]           req_symbol;
   logic [SB-1:0]           load_sym_addr;
   logic [PB-1:0]           load_pair_addr;
   logic [PB-1:0]           score_pair_addr;
   logic [2*SB-1:0]         pair_full;
   bes_pkg::cost_entry_type load_entry;

   // Text tracking at the front
   logic [SB-1:0] prev_byte_ff, prev_byte_in;
   logic          first_ff, first_in;

   // Scoring stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_first_ff;
   logic                    s1_last_ff;
   logic                    s1_go;
   logic                    s1_fire;
   bes_pkg::cost_entry_type utf8_sym_rd_ff, win_sym_rd_ff;
   bes_pkg::cost_entry_type utf8_pair_rd_ff, win_pair_rd_ff;

   // Totals
   logic [TW-1:0] utf8_total_ff, utf8_total_in;
   logic [TW-1:0] win_total_ff, win_total_in;
   logic [TW-1:0] utf8_sum, win_sum;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          guess_ff;
   logic [TW-1:0] score_utf8_ff, score_win_ff;

   // Opcode decoder
   always_comb begin
      is_score     = 1'b0;
      is_load_sym  = 1'b0;
      is_load_pair = 1'b0;
      unique case (req_opcode)
         bes_pkg::OP_SCORE:       is_score     = 1'b1;
         bes_pkg::OP_LOAD_SYMBOL: is_load_sym  = 1'b1;
         bes_pkg::OP_LOAD_PAIR:   is_load_pair = 1'b1;
         default: ;
      endcase
   end

   // Addresses and load data
   assign req_symbol      = req_data_byte[SB-1:0];
   assign load_sym_addr   = req_table_index[SB-1:0];
   assign load_pair_addr  = req_table_index[PB-1:0];
   assign pair_full       = {prev_byte_ff, req_symbol};
   assign score_pair_addr = PB'(pair_full);
   assign load_entry      = '{present: req_cost_present, cost: req_cost_value};

   // Handshake: the scoring stage moves on unless its result has nowhere to go
   assign s1_go     = !s1_valid_ff || !s1_last_ff || !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && s1_go;
   assign req_stall = !s1_go;
   assign accept    = req_valid && !req_stall;

   // UTF-8 symbol table
   always_ff @(posedge clock) begin
      if (accept && is_load_sym && (req_model_select == bes_pkg::MODEL_UTF8)) begin
         utf8_sym_mem[load_sym_addr] <= load_entry;
      end
      if (accept && is_score) begin
         utf8_sym_rd_ff <= utf8_sym_mem[req_symbol];
      end
   end

   // Windows-1251 symbol table
   always_ff @(posedge clock) begin
      if (accept && is_load_sym && (req_model_select == bes_pkg::MODEL_WIN1251)) begin
         win_sym_mem[load_sym_addr] <= load_entry;
      end
      if (accept && is_score) begin
         win_sym_rd_ff <= win_sym_mem[req_symbol];
      end
   end

   // UTF-8 pair table
   always_ff @(posedge clock) begin
      if (accept && is_load_pair && (req_model_select == bes_pkg::MODEL_UTF8)) begin
         utf8_pair_mem[load_pair_addr] <= load_entry;
      end
      if (accept && is_score) begin
         utf8_pair_rd_ff <= utf8_pair_mem[score_pair_addr];
      end
   end

   // Windows-1251 pair table
   always_ff @(posedge clock) begin
      if (accept && is_load_pair && (req_model_select == bes_pkg::MODEL_WIN1251)) begin
         win_pair_mem[load_pair_addr] <= load_entry;
      end
      if (accept && is_score) begin
         win_pair_rd_ff <= win_pair_mem[score_pair_addr];
      end
   end

   // Previous byte and text start, tracked as text beats are accepted
   always_comb begin
      prev_byte_in = prev_byte_ff;
      first_in     = first_ff;
      if (accept && is_score) begin
         if (req_end_of_text) begin
            prev_byte_in = '0;
            first_in     = 1'b1;
         end else begin
            prev_byte_in = req_symbol;
            first_in     = 1'b0;
         end
      end
   end

   // Scoring stage valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = is_score;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Per-model saturating add
   function automatic logic [TW-1:0] score_add(
      input logic [TW-1:0]         total,
      input bes_pkg::cost_entry_type sym,
      input bes_pkg::cost_entry_type pair,
      input logic                  first
   );
      logic [CW:0]   addend;
      logic [TW:0]   sum;
      logic          use_it;
      addend = first ? {1'b0, sym.cost} : ({1'b0, sym.cost} + {1'b0, pair.cost});
      use_it = first ? sym.present : (sym.present && pair.present);
      sum    = {1'b0, total} + (TW+1)'(addend);
      if (!use_it) begin
         return total;
      end else if (sum[TW]) begin
         return '1;
      end else begin
         return sum[TW-1:0];
      end
   endfunction

   assign utf8_sum = score_add(utf8_total_ff, utf8_sym_rd_ff, utf8_pair_rd_ff, s1_first_ff);
   assign win_sum  = score_add(win_total_ff, win_sym_rd_ff, win_pair_rd_ff, s1_first_ff);

   // Totals: clear after the last byte of a text
   always_comb begin
      utf8_total_in = utf8_total_ff;
      win_total_in  = win_total_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            utf8_total_in = '0;
            win_total_in  = '0;
         end else begin
            utf8_total_in = utf8_sum;
            win_total_in  = win_sum;
         end
      end
   end

   // Result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff  <= '0;
         first_ff      <= 1'b1;
         s1_valid_ff   <= 1'b0;
         utf8_total_ff <= '0;
         win_total_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_byte_ff  <= prev_byte_in;
         first_ff      <= first_in;
         s1_valid_ff   <= s1_valid_in;
         utf8_total_ff <= utf8_total_in;
         win_total_ff  <= win_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Scoring stage payload
   always_ff @(posedge clock) begin
      if (accept && is_score) begin
         s1_first_ff <= first_ff;
         s1_last_ff  <= req_end_of_text;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         guess_ff      <= (utf8_sum > win_sum) ? bes_pkg::GUESS_UTF8
                                               : bes_pkg::GUESS_WIN1251;
         score_utf8_ff <= utf8_sum;
         score_win_ff  <= win_sum;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_encoding_guess = guess_ff;
   assign rsp_score_utf8     = score_utf8_ff;
   assign rsp_score_win1251  = score_win_ff;

endmodule
